// ----- hw/rtl/cc20_pkg.sv -----
// Shared types, constants and helper functions of the ChaCha20 stream XOR unit.
// No dependencies; all other files refer to it by scoped names.
package cc20_pkg;

  // Number of rounds of the block function (8..20)
  localparam int unsigned ROUND_COUNT = 20;
  localparam int unsigned RND_W = $clog2(ROUND_COUNT);

  // Half quarter-round steps in one round: four columns, two halves each
  localparam int unsigned STEPS_PER_ROUND = 8;
  localparam int unsigned STEP_W = $clog2(STEPS_PER_ROUND);

  // Words in one block and bytes of keystream per block
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned WORD_IDX_W = $clog2(BLOCK_WORDS);
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BYTE_IDX_W = $clog2(BLOCK_BYTES);
  localparam int unsigned POS_W = BYTE_IDX_W + 1;

  // "expand 32-byte k", little-endian words
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  // Rotation amounts of the quarter-round
  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3,
    REG_NONCE_LOW  = 3'd4,
    REG_NONCE_HIGH = 3'd5
  } cc20_reg_e;

  typedef logic [7:0][31:0]             cc20_key_t;
  typedef logic [2:0][31:0]             cc20_nonce_t;
  typedef logic [BLOCK_WORDS-1:0][31:0] cc20_blk_t;

  // Operand set of one quarter-round
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } cc20_quad_t;

  // Top level to block function core
  typedef struct packed {
    logic start;
  } cc20_ctrl_t;

  // Block function core to top level
  typedef struct packed {
    logic done;
  } cc20_stat_t;

  // Top level sequencer
  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_GEN,
    TOP_EMIT
  } cc20_top_st_e;

  // Block function sequencer
  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FEED
  } cc20_core_st_e;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

  // Initial state word at a given position
  function automatic logic [31:0] init_word(input logic [WORD_IDX_W-1:0] idx,
                                            input cc20_key_t key,
                                            input cc20_nonce_t nonce,
                                            input logic [31:0] ctr);
    case (idx)
      4'd0:    init_word = SIGMA_0;
      4'd1:    init_word = SIGMA_1;
      4'd2:    init_word = SIGMA_2;
      4'd3:    init_word = SIGMA_3;
      4'd4:    init_word = key[0];
      4'd5:    init_word = key[1];
      4'd6:    init_word = key[2];
      4'd7:    init_word = key[3];
      4'd8:    init_word = key[4];
      4'd9:    init_word = key[5];
      4'd10:   init_word = key[6];
      4'd11:   init_word = key[7];
      4'd12:   init_word = ctr;
      4'd13:   init_word = nonce[0];
      4'd14:   init_word = nonce[1];
      4'd15:   init_word = nonce[2];
      default: init_word = '0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/cc20_round_unit.sv -----
// Shared half quarter-round datapath of the ChaCha20 block function.
// Depends on cc20_pkg.
module cc20_round_unit (
  input  cc20_pkg::cc20_quad_t quad_i,
  input  logic                 second_i,  // 0: rotations 16/12, 1: rotations 8/7
  output cc20_pkg::cc20_quad_t quad_o
);

  logic [31:0] a_sum;
  logic [31:0] d_rot;
  logic [31:0] c_sum;
  logic [31:0] b_rot;

  // a += b; d = rotl(d ^ a); c += d; b = rotl(b ^ c)
  always_comb begin
    a_sum = quad_i.a + quad_i.b;
    d_rot = second_i ? cc20_pkg::rotl32(quad_i.d ^ a_sum, cc20_pkg::ROT_C)
                     : cc20_pkg::rotl32(quad_i.d ^ a_sum, cc20_pkg::ROT_A);
    c_sum = quad_i.c + d_rot;
    b_rot = second_i ? cc20_pkg::rotl32(quad_i.b ^ c_sum, cc20_pkg::ROT_D)
                     : cc20_pkg::rotl32(quad_i.b ^ c_sum, cc20_pkg::ROT_B);
    quad_o.a = a_sum;
    quad_o.b = b_rot;
    quad_o.c = c_sum;
    quad_o.d = d_rot;
  end

endmodule

// ----- hw/rtl/cc20_core.sv -----
// ChaCha20 block function: state array, round sequencer and serial feed-forward.
// Depends on cc20_pkg and cc20_round_unit. The state array doubles as keystream buffer.
module cc20_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cc20_pkg::cc20_ctrl_t              ctrl_i,
  output cc20_pkg::cc20_stat_t              stat_o,
  input  cc20_pkg::cc20_key_t               key_i,
  input  cc20_pkg::cc20_nonce_t             nonce_i,
  input  logic [31:0]                       ctr_i,
  input  logic [cc20_pkg::BYTE_IDX_W-1:0]   rd_pos_i,
  output logic [7:0]                        ks_byte_o
);

  cc20_pkg::cc20_core_st_e           st_q, st_d;
  logic [cc20_pkg::RND_W-1:0]        round_q, round_d;
  logic [cc20_pkg::STEP_W-1:0]       step_q, step_d;
  logic [cc20_pkg::WORD_IDX_W-1:0]   ff_q, ff_d;
  cc20_pkg::cc20_blk_t               w_q, w_d;

  cc20_pkg::cc20_quad_t              quad_in;
  cc20_pkg::cc20_quad_t              quad_out;
  cc20_pkg::cc20_blk_t               tmp;
  logic [1:0]                        rot [4];
  logic                              last_step;
  logic                              last_round;
  logic [31:0]                       ks_word;

  // Column 0 of the (rotated) state always feeds the shared unit
  assign quad_in.a = w_q[0];
  assign quad_in.b = w_q[4];
  assign quad_in.c = w_q[8];
  assign quad_in.d = w_q[12];

  cc20_round_unit u_round (
    .quad_i   (quad_in),
    .second_i (step_q[0]),
    .quad_o   (quad_out)
  );

  assign last_step  = (step_q == cc20_pkg::STEP_W'(cc20_pkg::STEPS_PER_ROUND - 1));
  assign last_round = (round_q == cc20_pkg::RND_W'(cc20_pkg::ROUND_COUNT - 1));

  // Row rotation after a second half: next column moves into place; at the end
  // of a round the rows are also diagonalized or put back in natural order.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (!last_step) begin
        rot[r] = 2'd1;
      end else if (round_q[0]) begin
        rot[r] = 2'(1 - r);
      end else if (!last_round) begin
        rot[r] = 2'(1 + r);
      end else begin
        rot[r] = 2'd1;
      end
    end
  end

  // Sequencer and state update
  always_comb begin
    st_d     = st_q;
    round_d  = round_q;
    step_d   = step_q;
    ff_d     = ff_q;
    w_d      = w_q;
    tmp      = w_q;
    stat_o.done = 1'b0;
    case (st_q)
      cc20_pkg::CORE_IDLE: begin
        if (ctrl_i.start) begin
          for (int i = 0; i < cc20_pkg::BLOCK_WORDS; i++) begin
            w_d[i] = cc20_pkg::init_word(cc20_pkg::WORD_IDX_W'(i), key_i, nonce_i, ctr_i);
          end
          round_d = '0;
          step_d  = '0;
          st_d    = cc20_pkg::CORE_ROUND;
        end
      end
      cc20_pkg::CORE_ROUND: begin
        tmp[0]  = quad_out.a;
        tmp[4]  = quad_out.b;
        tmp[8]  = quad_out.c;
        tmp[12] = quad_out.d;
        if (step_q[0]) begin
          for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
              w_d[4*r + j] = tmp[{2'(r), 2'(j) + rot[r]}];
            end
          end
        end else begin
          w_d = tmp;
        end
        step_d = step_q + 1'b1;
        if (last_step) begin
          if (last_round) begin
            ff_d = '0;
            st_d = cc20_pkg::CORE_FEED;
          end else begin
            round_d = round_q + 1'b1;
          end
        end
      end
      cc20_pkg::CORE_FEED: begin
        // Shift the array by one word, adding the initial word as it wraps
        for (int i = 0; i < cc20_pkg::BLOCK_WORDS - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[cc20_pkg::BLOCK_WORDS-1] = w_q[0] +
            cc20_pkg::init_word(ff_q, key_i, nonce_i, ctr_i);
        ff_d = ff_q + 1'b1;
        if (ff_q == cc20_pkg::WORD_IDX_W'(cc20_pkg::BLOCK_WORDS - 1)) begin
          stat_o.done = 1'b1;
          st_d        = cc20_pkg::CORE_IDLE;
        end
      end
      default: begin
        st_d = cc20_pkg::CORE_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= cc20_pkg::CORE_IDLE;
      round_q <= '0;
      step_q  <= '0;
      ff_q    <= '0;
    end else begin
      st_q    <= st_d;
      round_q <= round_d;
      step_q  <= step_d;
      ff_q    <= ff_d;
    end
  end

  // State array, no reset
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  // Keystream byte select, little-endian within the word
  assign ks_word   = w_q[rd_pos_i[cc20_pkg::BYTE_IDX_W-1:2]];
  assign ks_byte_o = 8'(ks_word >> {rd_pos_i[1:0], 3'b000});

endmodule

// ----- hw/rtl/chacha20_stream_xor_unit.sv -----
// ChaCha20 stream XOR unit: one byte per beat, XORed with the next keystream byte.
// While buffered keystream remains, a beat's result is registered for the cycle after
// acceptance. When a new block is needed, the core loads the state and runs the half
// quarter-round steps of the shared round unit and the serial feed-forward before the
// beat is emitted; no new beat is taken meanwhile. Reset: counter 0, keystream marked
// used up, key and nonce registers 0, output empty. Depends on cc20_pkg and cc20_core.
module chacha20_stream_xor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]                     cfg_data_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
  input  logic                            s_axis_tuser,   // [0] restart
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata    // [7:0] result_byte
);

  cc20_pkg::cc20_top_st_e             st_q, st_d;
  logic [cc20_pkg::POS_W-1:0]         pos_q, pos_d;
  logic [31:0]                        ctr_q, ctr_d;
  logic                               out_valid_q, out_valid_d;
  logic [7:0]                         out_data_q, out_data_d;
  logic [7:0]                         data_q, data_d;
  cc20_pkg::cc20_key_t                key_q;
  cc20_pkg::cc20_nonce_t              nonce_q;

  cc20_pkg::cc20_ctrl_t               ctrl;
  cc20_pkg::cc20_stat_t               stat;
  logic                               in_acc;
  logic                               need_block;
  logic [31:0]                        ctr_eff;
  logic [cc20_pkg::BYTE_IDX_W-1:0]    rd_pos;
  logic [7:0]                         ks_byte;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cc20_pkg::REG_KEY_WORD_0: key_q[1:0] <= cfg_data_i;
        cc20_pkg::REG_KEY_WORD_1: key_q[3:2] <= cfg_data_i;
        cc20_pkg::REG_KEY_WORD_2: key_q[5:4] <= cfg_data_i;
        cc20_pkg::REG_KEY_WORD_3: key_q[7:6] <= cfg_data_i;
        cc20_pkg::REG_NONCE_LOW:  nonce_q[1:0] <= cfg_data_i;
        cc20_pkg::REG_NONCE_HIGH: nonce_q[2] <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign s_axis_tready = (st_q == cc20_pkg::TOP_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign need_block    = s_axis_tuser || pos_q[cc20_pkg::POS_W-1];
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A restart beat starts its block from counter zero
  assign ctr_eff    = (in_acc && s_axis_tuser) ? '0 : ctr_q;
  assign ctrl.start = in_acc && need_block;
  assign rd_pos     = (st_q == cc20_pkg::TOP_EMIT) ? '0 : pos_q[cc20_pkg::BYTE_IDX_W-1:0];

  cc20_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .key_i     (key_q),
    .nonce_i   (nonce_q),
    .ctr_i     (ctr_eff),
    .rd_pos_i  (rd_pos),
    .ks_byte_o (ks_byte)
  );

  // Sequencer: serve buffered bytes directly, otherwise wait for a new block
  always_comb begin
    st_d        = st_q;
    pos_d       = pos_q;
    ctr_d       = ctr_q;
    data_d      = data_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    case (st_q)
      cc20_pkg::TOP_IDLE: begin
        if (in_acc) begin
          if (need_block) begin
            data_d = s_axis_tdata;
            ctr_d  = ctr_eff;
            st_d   = cc20_pkg::TOP_GEN;
          end else begin
            out_data_d  = s_axis_tdata ^ ks_byte;
            out_valid_d = 1'b1;
            pos_d       = pos_q + 1'b1;
          end
        end
      end
      cc20_pkg::TOP_GEN: begin
        if (stat.done) begin
          st_d = cc20_pkg::TOP_EMIT;
        end
      end
      cc20_pkg::TOP_EMIT: begin
        out_data_d  = data_q ^ ks_byte;
        out_valid_d = 1'b1;
        pos_d       = cc20_pkg::POS_W'(1);
        ctr_d       = ctr_q + 1'b1;
        st_d        = cc20_pkg::TOP_IDLE;
      end
      default: begin
        st_d = cc20_pkg::TOP_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= cc20_pkg::TOP_IDLE;
      pos_q       <= cc20_pkg::POS_W'(cc20_pkg::BLOCK_BYTES);
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pos_q       <= pos_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_data_q <= out_data_d;
  end

endmodule

// ----- verif/tb.sv -----
// Testbench for chacha20_stream_xor_unit: byte stream XOR with ChaCha20 keystream.
// Carries its own block-function model; drives random gaps and stalls on both streams.
// Depends on cc20_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb;

  // Index outside the register map: the write must be ignored
  localparam logic [cc20_pkg::CFG_IDX_W-1:0] NO_SUCH_REG = 3'd7;
  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned BLOCK_SIZE   = 64;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0]                    cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;   // [7:0] data_byte
  logic                           s_axis_tuser = 1'b0; // [0] restart
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;        // [7:0] result_byte

  chacha20_stream_xor_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Directed bytes; with key and nonce zero the keystream starts 76 b8 e0 ad a0 f1
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       fixed;
    logic [7:0] want;
  } dir_row_t;

  dir_row_t dir_rows [22] = '{
    '{8'h00, 1'b0, 1'b1, 8'h76},
    '{8'hff, 1'b0, 1'b1, 8'h47},
    '{8'h00, 1'b0, 1'b1, 8'he0},
    '{8'h00, 1'b0, 1'b1, 8'had},
    '{8'h00, 1'b1, 1'b1, 8'h76},  // restart rewinds to byte 0 of block 0
    '{8'h00, 1'b0, 1'b1, 8'hb8},
    '{8'ha5, 1'b0, 1'b1, 8'h45},
    '{8'hff, 1'b0, 1'b1, 8'h52},
    '{8'h00, 1'b0, 1'b1, 8'ha0},
    '{8'h00, 1'b0, 1'b1, 8'hf1},
    '{8'hff, 1'b1, 1'b1, 8'h89},
    '{8'h5a, 1'b0, 1'b1, 8'he2},
    '{8'h01, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 8'h00},
    '{8'h7f, 1'b0, 1'b0, 8'h00},
    '{8'hfe, 1'b0, 1'b0, 8'h00},
    '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'haa, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 8'h00},  // two restarts in a row
    '{8'h3c, 1'b1, 1'b0, 8'h00},
    '{8'hc3, 1'b0, 1'b0, 8'h00},
    '{8'hff, 1'b0, 1'b0, 8'h00}
  };

  // Keystream model state
  logic [63:0] key_shadow [4];
  logic [63:0] nonce_lo;
  logic [31:0] nonce_hi;
  logic [31:0] ks_words [16];
  logic [31:0] mix [16];
  logic [31:0] blk_ctr;
  int unsigned ks_pos;

  logic [7:0]  pending_cipher [$];
  int unsigned mismatch_count = 0;
  int unsigned random_sent = 0;
  int unsigned restart_count = 0;
  int unsigned reg_writes = 0;
  int unsigned setting_count = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter_mix(input int a, input int b, input int c, input int d);
    mix[a] += mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
    mix[c] += mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
    mix[a] += mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
    mix[c] += mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
  endfunction

  // Block function for the current counter, with feed-forward
  function automatic void refill_keystream();
    logic [31:0] start_st [16];
    start_st[0]  = 32'h6170_7865;
    start_st[1]  = 32'h3320_646e;
    start_st[2]  = 32'h7962_2d32;
    start_st[3]  = 32'h6b20_6574;
    for (int k = 0; k < 4; k++) begin
      start_st[4 + 2*k] = key_shadow[k][31:0];
      start_st[5 + 2*k] = key_shadow[k][63:32];
    end
    start_st[12] = blk_ctr;
    start_st[13] = nonce_lo[31:0];
    start_st[14] = nonce_lo[63:32];
    start_st[15] = nonce_hi;
    for (int i = 0; i < 16; i++) mix[i] = start_st[i];
    for (int r = 0; r < cc20_pkg::ROUND_COUNT; r++) begin
      if (r % 2 == 0) begin
        quarter_mix(0, 4, 8, 12);
        quarter_mix(1, 5, 9, 13);
        quarter_mix(2, 6, 10, 14);
        quarter_mix(3, 7, 11, 15);
      end else begin
        quarter_mix(0, 5, 10, 15);
        quarter_mix(1, 6, 11, 12);
        quarter_mix(2, 7, 8, 13);
        quarter_mix(3, 4, 9, 14);
      end
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + start_st[i];
  endfunction

  // Next output byte for one accepted input beat; advances the model
  function automatic logic [7:0] cipher_byte(input logic [7:0] data, input logic restart);
    logic [7:0] ks;
    if (restart) begin
      blk_ctr = '0;
      ks_pos  = BLOCK_SIZE;
    end
    if (ks_pos >= BLOCK_SIZE) begin
      refill_keystream();
      blk_ctr = blk_ctr + 32'd1;
      ks_pos  = 0;
    end
    ks = ks_words[ks_pos / 4][8 * (ks_pos % 4) +: 8];
    ks_pos++;
    return data ^ ks;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Register write; valid stays high for a following write, caller lowers it
  task automatic write_reg(input logic [cc20_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    case (idx)
      cc20_pkg::REG_KEY_WORD_0: key_shadow[0] = val;
      cc20_pkg::REG_KEY_WORD_1: key_shadow[1] = val;
      cc20_pkg::REG_KEY_WORD_2: key_shadow[2] = val;
      cc20_pkg::REG_KEY_WORD_3: key_shadow[3] = val;
      cc20_pkg::REG_NONCE_LOW:  nonce_lo = val;
      cc20_pkg::REG_NONCE_HIGH: nonce_hi = val[31:0];
      default: ;
    endcase
  endtask

  // One input beat; an optional fixed value overrides the model's expectation
  task automatic send_byte(input logic [7:0] data, input logic restart,
                           input logic fixed, input logic [7:0] want);
    int unsigned gap;
    logic [7:0]  model_out;
    gap = pick_idle();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    if (restart) restart_count++;
    model_out = cipher_byte(data, restart);
    pending_cipher.push_back(fixed ? want : model_out);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk_i);
  endtask

  // New key and nonce between phases: random, all zero, all ones, or a few registers
  task automatic load_setting(input int unsigned kind);
    logic [63:0] v;
    for (int i = 0; i < 6; i++) begin
      case (kind)
        1: v = '0;
        2: v = '1;
        default: v = {$urandom, $urandom};
      endcase
      if (kind != 3 || $urandom_range(0, 1) == 1)
        write_reg(i[cc20_pkg::CFG_IDX_W-1:0], v);
    end
    if (kind == 3) write_reg(NO_SUCH_REG, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  // Output side back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left <= pick_idle();
    end
  end

  // Output check against the oldest expectation
  always @(posedge clk_i) begin : check_out
    logic [7:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cipher.size() == 0) begin
        report_mismatch($sformatf("unexpected beat result_byte=%02h", m_axis_tdata));
      end else begin
        want = pending_cipher.pop_front();
        if (m_axis_tdata !== want)
          report_mismatch($sformatf("result_byte got %02h want %02h", m_axis_tdata, want));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_cipher.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned phase_len;
    int unsigned phase_no;
    logic [7:0]  d;
    logic        rs;
    for (int k = 0; k < 4; k++) key_shadow[k] = '0;
    nonce_lo = '0;
    nonce_hi = '0;
    for (int i = 0; i < 16; i++) ks_words[i] = '0;
    blk_ctr = '0;
    ks_pos  = BLOCK_SIZE;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset key and nonce
    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].restart, dir_rows[i].fixed, dir_rows[i].want);
    drain_results();

    // Random phases, each under a new setting written while idle mid-block
    phase_no = 0;
    while (random_sent < RANDOM_BYTES) begin
      no_idle = (phase_no % 3 == 2);
      load_setting(phase_no == 0 ? 2 : (phase_no % 4));
      phase_len = $urandom_range(30, 160);
      for (int n = 0; n < phase_len; n++) begin
        d  = 8'($urandom_range(0, 255));
        rs = ($urandom_range(0, 99) < 3);
        send_byte(d, rs, 1'b0, 8'h00);
        random_sent++;
      end
      drain_results();
      phase_no++;
    end
    no_idle = 1'b0;

    repeat (200) @(posedge clk_i);
    $display("covered %0d directed and %0d random bytes, %0d restarts",
             $size(dir_rows), random_sent, restart_count);
    $display("under %0d key/nonce settings with %0d register writes, %0d mismatches",
             setting_count, reg_writes, mismatch_count);
    if (mismatch_count == 0 && pending_cipher.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- chacha20_stream_xor_unit.f -----
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_round_unit.sv
hw/rtl/cc20_core.sv
hw/rtl/chacha20_stream_xor_unit.sv
verif/tb.sv
